// File: sv/bmhpq_pkg.sv
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Shared types and constants for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

  localparam int unsigned CAPACITY_DEF      = 64;
  localparam int unsigned DATA_BITS_DEF     = 32;
  localparam int unsigned PRIORITY_BITS_DEF = 32;

  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned COUNT_BITS = 7;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    MODE_INSERT  = 1'b0,
    MODE_EXTRACT = 1'b1
  } mode_t;

endpackage

// File: sv/binary_max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Fixed-capacity max-heap of (data, priority) entries kept in one memory.
// ----------------------------------------------------------------------------
// Usage: raise start with in_mode, in_item_data and in_item_priority while
// busy is low; the request is taken at that edge and busy rises. Insert
// appends the entry and sifts it up; extract returns the root's data and
// sifts the last entry down from the root. Each request yields exactly one
// result, shown for one cycle with out_valid: out_data, out_status,
// out_entry_count and out_heap_empty. The receiver cannot stall.
// Timing: the heap lies in a single memory with a registered read, one read
// port and one write port. Busy stays high while an insert climbs or an
// extract sinks, and while an error request passes to its result. The
// result shows in the first cycle with busy low, and a new request may be
// taken in that same cycle.
// Reset clears the count and control state; memory contents are left as they
// are, as only occupied entries are ever used.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue
  import bmhpq_pkg::*;
#(
  parameter int unsigned CAPACITY      = CAPACITY_DEF,
  parameter int unsigned DATA_BITS     = DATA_BITS_DEF,
  parameter int unsigned PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic signed [FIELD_BITS-1:0] in_item_data,
  input  logic signed [FIELD_BITS-1:0] in_item_priority,
  output logic                         out_valid,
  output logic signed [FIELD_BITS-1:0] out_data,
  output logic [1:0]                   out_status,
  output logic [COUNT_BITS-1:0]        out_entry_count,
  output logic                         out_heap_empty
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = DATA_BITS + PRIORITY_BITS;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_UPRD  = 11'b00000000010, // read parent
    S_UPCMP = 11'b00000000100, // compare, write parent
    S_UPWR  = 11'b00000001000, // write child
    S_XRD0  = 11'b00000010000, // read root
    S_XRDL  = 11'b00000100000,
    S_DNRL  = 11'b00001000000, // read left child
    S_DNRR  = 11'b00010000000, // read right child
    S_DNCMP = 11'b00100000000,
    S_DNWR  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  // Memory: data in high bits, priority in low bits.
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rdata_r;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   pick_r, pick_nxt;
  logic [EW-1:0]   cur_r, cur_nxt;    // moving entry
  logic [EW-1:0]   left_r, left_nxt;
  logic [EW-1:0]   other_r, other_nxt;  // compared entry
  logic [DATA_BITS-1:0] res_data_r, res_data_nxt;
  status_t         res_st_r, res_st_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            prev_xrdl_r;

  function automatic logic signed [PRIORITY_BITS-1:0] prio(input logic [EW-1:0] e);
    return e[PRIORITY_BITS-1:0];
  endfunction

  logic [CW:0] l_idx, r_idx, cnt_w;
  assign l_idx = {{(CW-AW){1'b0}}, idx_r, 1'b1};
  assign r_idx = l_idx + 1'b1;
  assign cnt_w = {1'b0, count_r};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pick_nxt      = pick_r;
    cur_nxt       = cur_r;
    left_nxt      = left_r;
    other_nxt     = other_r;
    res_data_nxt  = res_data_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = 1'b0;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = cur_r;
    raddr         = idx_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          res_data_nxt = '0;
          res_st_nxt   = ST_OK;
          if (in_mode == MODE_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              cur_nxt   = {in_item_data[DATA_BITS-1:0], in_item_priority[PRIORITY_BITS-1:0]};
              idx_nxt   = count_r[AW-1:0];
              count_nxt = count_r + 1'b1;
              state_nxt = S_UPRD;
            end
          end else if (count_r == '0) begin
            res_st_nxt = ST_EMPTY;
            state_nxt  = S_DONE;
          end else begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_XRD0;
          end
        end
      end
      S_UPRD: begin
        if (idx_r == '0) begin
          we        = 1'b1;
          state_nxt = S_DONE;
        end else begin
          raddr     = (idx_r - 1'b1) >> 1;
          pick_nxt  = (idx_r - 1'b1) >> 1;
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (prio(rdata_r) < prio(cur_r)) begin
          // Parent moves down into the hole; the entry climbs.
          we        = 1'b1;
          wdata     = rdata_r;
          idx_nxt   = pick_r;
          state_nxt = S_UPRD;
        end else begin
          state_nxt = S_UPWR;
        end
      end
      S_UPWR: begin
        we        = 1'b1;
        state_nxt = S_DONE;
      end
      S_XRD0: begin
        raddr     = '0;
        state_nxt = S_XRDL;
      end
      S_XRDL: begin
        res_data_nxt = rdata_r[EW-1:PRIORITY_BITS];
        raddr        = count_r[AW-1:0];
        idx_nxt      = '0;
        state_nxt    = S_DNRL;
      end
      S_DNRL: begin
        if (l_idx < cnt_w) begin
          raddr     = l_idx[AW-1:0];
          state_nxt = S_DNRR;
        end else begin
          state_nxt = S_DNWR;
        end
      end
      S_DNRR: begin
        left_nxt  = rdata_r;
        raddr     = r_idx[AW-1:0];
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        if (r_idx < cnt_w && !(prio(left_r) > prio(rdata_r))) begin
          other_nxt = rdata_r;
          pick_nxt  = r_idx[AW-1:0];
        end else begin
          other_nxt = left_r;
          pick_nxt  = l_idx[AW-1:0];
        end
        if (prio(cur_r) < prio(other_nxt)) begin
          we        = 1'b1;
          wdata     = other_nxt;
          idx_nxt   = pick_nxt;
          state_nxt = S_DNRL;
        end else begin
          state_nxt = S_DNWR;
        end
      end
      S_DNWR: begin
        we        = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // The last entry arrives on the read port in the cycle after S_XRDL issues
    // its read, so the first pass through S_DNRL takes it from there.
    if (state_r == S_DNRL && prev_xrdl_r) begin
      cur_nxt = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_xrdl_r <= 1'b0;
    end else begin
      prev_xrdl_r <= (state_r == S_XRDL);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pick_r     <= pick_nxt;
    cur_r      <= cur_nxt;
    left_r     <= left_nxt;
    other_r    <= other_nxt;
    res_data_r <= res_data_nxt;
    res_st_r   <= res_st_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_data        = FIELD_BITS'(signed'(res_data_r));
  assign out_status      = res_st_r;
  assign out_entry_count = COUNT_BITS'(count_r);
  assign out_heap_empty  = (count_r == '0);

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("heap count above capacity");

  // A result follows in the cycle after the done state.
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> out_valid) else $error("missing result");

  // An error leaves the count unchanged.
  a_err_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> $stable(count_r))
    else $error("count changed on error");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert and extract requests into the max-heap priority queue and
// checks every result against a behavioral heap kept alongside the block.
// ----------------------------------------------------------------------------
module testbench;
  import bmhpq_pkg::*;

  localparam int HEAP_SIZE = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic signed [31:0] data;
    status_t            status;
    logic [6:0]         count;
    logic               empty;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic signed [31:0] in_item_data = '0;
  logic signed [31:0] in_item_priority = '0;
  logic out_valid;
  logic signed [31:0] out_data;
  logic [1:0] out_status;
  logic [6:0] out_entry_count;
  logic out_heap_empty;

  // Behavioral heap state.
  logic signed [31:0] heap_data [HEAP_SIZE];
  logic signed [31:0] heap_prio [HEAP_SIZE];
  int heap_fill = 0;

  heap_result_t pending_results[$];
  int mismatch_count = 0;
  int unsigned cycle_count = 0;
  int sender_idle_pct = 0;

  binary_max_heap_priority_queue dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_item_data(in_item_data),
    .in_item_priority(in_item_priority), .out_valid(out_valid),
    .out_data(out_data), .out_status(out_status),
    .out_entry_count(out_entry_count), .out_heap_empty(out_heap_empty)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic swap_entries(input int a, input int b);
    logic signed [31:0] t;
    t = heap_data[a]; heap_data[a] = heap_data[b]; heap_data[b] = t;
    t = heap_prio[a]; heap_prio[a] = heap_prio[b]; heap_prio[b] = t;
  endtask

  // Applies one request to the behavioral heap and returns its result.
  task automatic predict_heap_op(input mode_t op, input logic signed [31:0] d,
                                 input logic signed [31:0] p,
                                 output heap_result_t r);
    int idx;
    int par;
    int l;
    int pick;
    r.data = '0;
    r.status = ST_OK;
    if (op == MODE_INSERT) begin
      if (heap_fill >= HEAP_SIZE) begin
        r.status = ST_FULL;
      end else begin
        idx = heap_fill;
        heap_fill++;
        heap_data[idx] = d;
        heap_prio[idx] = p;
        while (idx > 0) begin
          par = (idx - 1) / 2;
          if (heap_prio[par] < heap_prio[idx]) begin
            swap_entries(par, idx);
            idx = par;
          end else begin
            break;
          end
        end
      end
    end else if (heap_fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      heap_fill--;
      r.data = heap_data[0];
      heap_data[0] = heap_data[heap_fill];
      heap_prio[0] = heap_prio[heap_fill];
      idx = 0;
      while (2 * idx + 1 < heap_fill) begin
        l = 2 * idx + 1;
        pick = l;
        if (l + 1 < heap_fill) pick = (heap_prio[l] > heap_prio[l + 1]) ? l : l + 1;
        if (heap_prio[idx] < heap_prio[pick]) begin
          swap_entries(idx, pick);
          idx = pick;
        end else begin
          break;
        end
      end
    end
    r.count = heap_fill[6:0];
    r.empty = (heap_fill == 0);
  endtask

  // Sends one request, with a random idle gap before it.
  task automatic send_request(input mode_t op, input logic signed [31:0] d,
                              input logic signed [31:0] p);
    heap_result_t r;
    while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    start <= 1'b1;
    in_mode <= op;
    in_item_data <= d;
    in_item_priority <= p;
    do @(posedge clk); while (busy);
    predict_heap_op(op, d, p, r);
    pending_results.push_back(r);
    start <= 1'b0;
    // Busy is high in the cycle after acceptance, so this costs no throughput.
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    heap_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result at cycle %0d", cycle_count);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data !== exp_r.data || out_status !== exp_r.status ||
            out_entry_count !== exp_r.count || out_heap_empty !== exp_r.empty) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected data %0d status %0d count %0d empty %0d, ",
                      "got %0d %0d %0d %0d"},
                     exp_r.data, exp_r.status, exp_r.count, exp_r.empty,
                     out_data, out_status, out_entry_count, out_heap_empty);
        end
      end
    end
  end

  function automatic logic signed [31:0] random_word();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'(signed'($urandom_range(8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Error on empty, extreme fields, drain, error on empty again.
  task automatic test_directed();
    send_request(MODE_EXTRACT, 32'sd5, 32'sd5);
    send_request(MODE_INSERT, 32'sh7fffffff, 32'sh80000000);
    send_request(MODE_INSERT, 32'sh80000000, 32'sh7fffffff);
    send_request(MODE_INSERT, 32'sd0, 32'sd0);
    send_request(MODE_INSERT, -32'sd1, -32'sd1);
    send_request(MODE_INSERT, 32'sh55555555, 32'sd0);
    send_request(MODE_INSERT, 32'shaaaaaaaa, 32'sd0);
    for (int i = 0; i < 6; i++) send_request(MODE_EXTRACT, 32'sd0, 32'sd0);
    send_request(MODE_EXTRACT, -32'sd1, -32'sd1);
    wait_drained();
  endtask

  task automatic test_full_heap();
    for (int i = 0; i < HEAP_SIZE + 3; i++)
      send_request(MODE_INSERT, $urandom, 32'($urandom_range(7)));
    for (int i = 0; i < HEAP_SIZE + 2; i++) send_request(MODE_EXTRACT, $urandom, $urandom);
  endtask

  // Random walks with a drifting insert bias so the fill level sweeps widely.
  task automatic test_random(input int n, input int idle_pct);
    int bias;
    sender_idle_pct = idle_pct;
    bias = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) bias = $urandom_range(20, 80);
      if ($urandom_range(99) < bias)
        send_request(MODE_INSERT, random_word(), random_word());
      else
        send_request(MODE_EXTRACT, random_word(), random_word());
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_heap();
    test_random(250, 0);
    test_random(250, 75);
    test_random(250, 7);
    test_random(250, 0);
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
sv/bmhpq_pkg.sv
sv/binary_max_heap_priority_queue.sv
test/testbench.sv
